FILE: rtl/core/bvm_pkg.sv
`default_nettype none

package bvm_pkg;

  // Size of the byte memory and of the register file.
  localparam int MEM_BYTES = 8192;
  localparam int NUM_REGS  = 8;

  localparam int MADDR_W = $clog2(MEM_BYTES);
  localparam int RIDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Operation codes of a decoded instruction.
  typedef enum logic [3:0] {
    OP_HALT  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_STORE = 4'd2,
    OP_MOVE  = 4'd3,
    OP_PUTI  = 4'd4,
    OP_ADD   = 4'd5,
    OP_SUB   = 4'd6,
    OP_GT    = 4'd7,
    OP_GE    = 4'd8,
    OP_EQ    = 4'd9,
    OP_ITE   = 4'd10,
    OP_JUMP  = 4'd11
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_HALT     = 2'd1,
    ST_MEMFAULT = 2'd2,
    ST_REGFAULT = 2'd3
  } status_t;

  // One register file write.
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [31:0]       data;
  } rf_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/byte_vm_instruction_execute_top.sv
`default_nettype none

// Instruction executor of a small byte-addressed register machine. Each input
// item is one decoded instruction (op and three operand bytes); each one gives
// exactly one result item with the status, the program counter after the
// instruction and the value written, if any. The block takes one item per clock
// cycle while the output side is not stalled: the synchronous register file read
// is issued at the accepting edge and execute uses its data in the following
// cycle, the byte memory is accessed as the item leaves execute, and the output
// register is loaded as the item leaves the memory stage. Results of an instruction
// still in the pipeline are forwarded to the next ones, so dependent instructions
// run back to back without stalls. After reset the byte memory is swept to zero
// over all MEM_BYTES bytes (8192 at the default size), during which in_ready stays
// low. The output register decouples the two sides: while a result waits, an item
// can still enter an empty execute stage.
module byte_vm_instruction_execute_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  op,
  input  wire logic [7:0]  operand_a,
  input  wire logic [7:0]  operand_b,
  input  wire logic [7:0]  operand_c,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      next_pc,
  output logic             write_valid,
  output logic [31:0]      write_value
);
  import bvm_pkg::*;

  localparam logic [8:0] REG_LIMIT = 9'(NUM_REGS);

  // Pipeline advance: every stage moves when the output register is free.
  logic advance;
  logic in_acc;
  logic mem_ready;

  // Execute stage registers.
  logic       s1_valid;
  logic [3:0] s1_op;
  logic [7:0] s1_a;
  logic [7:0] s1_b;
  logic [7:0] s1_c;

  // Architectural control state.
  logic [31:0] pc;
  logic        stopped;

  // Register file ports and forwarding.
  logic [RIDX_W-1:0] rd_idx_x;
  logic [RIDX_W-1:0] rd_idx_y;
  logic [31:0]       rf_x;
  logic [31:0]       rf_y;
  rf_wr_t            rf_wr;
  rf_wr_t            lastw;

  // Execute stage results.
  logic [RIDX_W-1:0] s1_ix;
  logic [RIDX_W-1:0] s1_iy;
  logic [31:0]       x;
  logic [31:0]       y;
  logic              reg_fault;
  logic              need_a;
  logic              need_b;
  logic              need_c;
  logic              addr_bad;
  status_t           ex_st;
  logic [31:0]       ex_npc;
  logic              ex_wv;
  logic [31:0]       ex_val;
  logic              ex_load;
  logic              ex_rwe;
  logic              ex_stop;
  logic              ex_mwe;

  // Memory stage registers.
  logic              s2_valid;
  logic [1:0]        s2_st;
  logic [31:0]       s2_npc;
  logic              s2_wv;
  logic [31:0]       s2_val;
  logic              s2_load;
  logic              s2_rwe;
  logic [RIDX_W-1:0] s2_widx;
  logic [7:0]        mem_rd;
  logic [31:0]       s2_final;

  assign advance  = ~out_valid | out_ready;
  assign in_ready = mem_ready & (advance | ~s1_valid);
  assign in_acc   = in_valid & in_ready;

  // Read port X serves the address register of a store and the condition of
  // ite; port Y serves the data register of a store. Otherwise X reads
  // operand b and Y operand c.
  always_comb begin
    rd_idx_x = (op == OP_STORE || op == OP_ITE) ? operand_a[RIDX_W-1:0]
                                                : operand_b[RIDX_W-1:0];
    rd_idx_y = (op == OP_STORE) ? operand_b[RIDX_W-1:0] : operand_c[RIDX_W-1:0];
  end

  bvm_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_acc),
    .rd_idx_x  (rd_idx_x),
    .rd_idx_y  (rd_idx_y),
    .rd_data_x (rf_x),
    .rd_data_y (rf_y),
    .wr        (rf_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // The write committed at the edge where an item enters execute is not seen
  // by its register read, so it is kept for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      lastw.en <= 1'b0;
    end else if (in_acc) begin
      lastw.en <= rf_wr.en;
    end
    if (in_acc) begin
      lastw.idx  <= rf_wr.idx;
      lastw.data <= rf_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op <= op;
      s1_a  <= operand_a;
      s1_b  <= operand_b;
      s1_c  <= operand_c;
    end
  end

  // Operand forwarding: the memory stage is newest, then the held write.
  always_comb begin
    s1_ix = (s1_op == OP_STORE || s1_op == OP_ITE) ? s1_a[RIDX_W-1:0]
                                                   : s1_b[RIDX_W-1:0];
    s1_iy = (s1_op == OP_STORE) ? s1_b[RIDX_W-1:0] : s1_c[RIDX_W-1:0];
    if (s2_valid && s2_rwe && s2_widx == s1_ix) begin
      x = s2_final;
    end else if (lastw.en && lastw.idx == s1_ix) begin
      x = lastw.data;
    end else begin
      x = rf_x;
    end
    if (s2_valid && s2_rwe && s2_widx == s1_iy) begin
      y = s2_final;
    end else if (lastw.en && lastw.idx == s1_iy) begin
      y = lastw.data;
    end else begin
      y = rf_y;
    end
  end

  // Which register operands the operation uses.
  always_comb begin
    need_a = 1'b0;
    need_b = 1'b0;
    need_c = 1'b0;
    unique case (s1_op) inside
      OP_LOAD, OP_STORE, OP_MOVE: begin
        need_a = 1'b1;
        need_b = 1'b1;
      end
      OP_PUTI, OP_ITE: begin
        need_a = 1'b1;
      end
      OP_ADD, OP_SUB, OP_GT, OP_GE, OP_EQ: begin
        need_a = 1'b1;
        need_b = 1'b1;
        need_c = 1'b1;
      end
      default: begin
      end
    endcase
    reg_fault = (need_a && {1'b0, s1_a} >= REG_LIMIT)
             || (need_b && {1'b0, s1_b} >= REG_LIMIT)
             || (need_c && {1'b0, s1_c} >= REG_LIMIT);
    addr_bad  = x >= 32'(MEM_BYTES);
  end

  // Execute step.
  always_comb begin
    ex_st   = ST_RUN;
    ex_npc  = pc + 32'd1;
    ex_wv   = 1'b0;
    ex_val  = '0;
    ex_load = 1'b0;
    ex_rwe  = 1'b0;
    ex_stop = 1'b0;
    ex_mwe  = 1'b0;
    if (stopped) begin
      ex_st  = ST_HALT;
      ex_npc = pc;
    end else if (reg_fault) begin
      ex_st  = ST_REGFAULT;
      ex_npc = pc;
    end else begin
      unique case (s1_op)
        OP_HALT: begin
          ex_st   = ST_HALT;
          ex_npc  = pc;
          ex_stop = 1'b1;
        end
        OP_LOAD: begin
          if (addr_bad) begin
            ex_st   = ST_MEMFAULT;
            ex_npc  = pc;
            ex_stop = 1'b1;
          end else begin
            ex_wv   = 1'b1;
            ex_load = 1'b1;
            ex_rwe  = 1'b1;
          end
        end
        OP_STORE: begin
          if (addr_bad) begin
            ex_st   = ST_MEMFAULT;
            ex_npc  = pc;
            ex_stop = 1'b1;
          end else begin
            ex_wv  = 1'b1;
            ex_val = {24'd0, y[7:0]};
            ex_mwe = 1'b1;
          end
        end
        OP_MOVE: begin
          ex_wv  = 1'b1;
          ex_val = x;
          ex_rwe = 1'b1;
        end
        OP_PUTI: begin
          ex_wv  = 1'b1;
          ex_val = {24'd0, s1_b};
          ex_rwe = 1'b1;
        end
        OP_ADD: begin
          ex_wv  = 1'b1;
          ex_val = x + y;
          ex_rwe = 1'b1;
        end
        OP_SUB: begin
          ex_wv  = 1'b1;
          ex_val = x - y;
          ex_rwe = 1'b1;
        end
        OP_GT: begin
          ex_wv  = 1'b1;
          ex_val = {31'd0, x > y};
          ex_rwe = 1'b1;
        end
        OP_GE: begin
          ex_wv  = 1'b1;
          ex_val = {31'd0, x >= y};
          ex_rwe = 1'b1;
        end
        OP_EQ: begin
          ex_wv  = 1'b1;
          ex_val = {31'd0, x == y};
          ex_rwe = 1'b1;
        end
        OP_ITE: begin
          ex_npc = (x != 32'd0) ? {24'd0, s1_b} : {24'd0, s1_c};
        end
        OP_JUMP: begin
          ex_npc = {24'd0, s1_a};
        end
        default: begin
        end
      endcase
    end
  end

  // The program counter and the stopped flag change as an item leaves
  // execute, so the next item always sees them up to date.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      stopped <= 1'b0;
    end else if (advance && s1_valid) begin
      pc      <= ex_npc;
      stopped <= stopped | ex_stop;
    end
  end

  // Stores write and loads read the byte memory as they leave execute; items
  // pass this point in order, so no hazard exists on the byte memory.
  bvm_bytemem u_bytemem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (advance & s1_valid & ex_load),
    .wr_en   (advance & s1_valid & ex_mwe),
    .addr    (x[MADDR_W-1:0]),
    .wr_data (y[7:0]),
    .rd_data (mem_rd),
    .ready   (mem_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_st   <= ex_st;
      s2_npc  <= ex_npc;
      s2_wv   <= ex_wv;
      s2_val  <= ex_val;
      s2_load <= ex_load;
      s2_rwe  <= ex_rwe & s1_valid;
      s2_widx <= s1_a[RIDX_W-1:0];
    end
  end

  assign s2_final = s2_load ? {24'd0, mem_rd} : s2_val;

  // Register file write-back as the item moves to the output register.
  always_comb begin
    rf_wr.en   = advance & s2_valid & s2_rwe;
    rf_wr.idx  = s2_widx;
    rf_wr.data = s2_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status      <= s2_st;
      next_pc     <= s2_npc;
      write_valid <= s2_wv;
      write_value <= s2_final;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bvm_regfile.sv
`default_nettype none

module bvm_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [bvm_pkg::RIDX_W-1:0] rd_idx_x,
  input  wire logic [bvm_pkg::RIDX_W-1:0] rd_idx_y,
  output logic [31:0]                     rd_data_x,
  output logic [31:0]                     rd_data_y,
  input  wire bvm_pkg::rf_wr_t            wr
);
  import bvm_pkg::*;

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [31:0]         rd_x;
  logic [31:0]         rd_y;
  logic                rd_xv;
  logic                rd_yv;

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_x  <= mem[rd_idx_x];
      rd_y  <= mem[rd_idx_y];
      rd_xv <= vld[rd_idx_x];
      rd_yv <= vld[rd_idx_y];
    end
  end

  assign rd_data_x = rd_xv ? rd_x : '0;
  assign rd_data_y = rd_yv ? rd_y : '0;

endmodule

`default_nettype wire

FILE: rtl/core/bvm_bytemem.sv
`default_nettype none

module bvm_bytemem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic                        wr_en,
  input  wire logic [bvm_pkg::MADDR_W-1:0] addr,
  input  wire logic [7:0]                  wr_data,
  output logic [7:0]                       rd_data,
  output logic                             ready
);
  import bvm_pkg::*;

  logic [7:0]         mem [MEM_BYTES];
  logic               clr_busy;
  logic [MADDR_W-1:0] clr_cnt;
  logic               we;
  logic [MADDR_W-1:0] wa;
  logic [7:0]         wd;

  // After reset the whole array is swept to zero, one byte a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == MADDR_W'(MEM_BYTES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign we = clr_busy | wr_en;
  assign wa = clr_busy ? clr_cnt : addr;
  assign wd = clr_busy ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign ready = ~clr_busy;

endmodule

`default_nettype wire

FILE: tb/sv/byte_vm_instruction_execute_top_test.sv
`default_nettype none

module byte_vm_instruction_execute_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bvm_pkg::*;

  // Operation codes 12 to 15 are not decoded; they only advance the program counter.
  localparam logic [3:0] OP_SPARE_FIRST = 4'd12;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  // Number of random instructions, and the point where the feeder holds off
  // until the pipeline has emptied completely.
  localparam int RANDOM_COUNT = 1500;
  localparam int DRAIN_POINT  = 700;
  // Instructions sent after the machine has been stopped.
  localparam int STOPPED_COUNT = 10;
  // Idle time after the last result; a margin above the block's own latency.
  localparam int SETTLE_CYCLES = 12;

  // One result item as it should appear at the output.
  typedef struct {
    status_t     st;
    logic [31:0] pc;
    logic        wr;
    logic [31:0] val;
  } result_t;

  // One instruction to send. Where typed is set, res holds an expectation that is
  // written out by hand; otherwise the expectation comes from the predictor.
  typedef struct {
    logic [3:0] opc;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    bit         typed;
    result_t    res;
  } instr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  op = '0;
  logic [7:0]  operand_a = '0;
  logic [7:0]  operand_b = '0;
  logic [7:0]  operand_c = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] next_pc;
  logic        write_valid;
  logic [31:0] write_value;

  byte_vm_instruction_execute_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .operand_c   (operand_c),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .next_pc     (next_pc),
    .write_valid (write_valid),
    .write_value (write_value)
  );

  always #5 clk = ~clk;

  // Shadow copy of the machine state, updated as each instruction is accepted.
  logic [31:0] reg_image [NUM_REGS];
  logic [7:0]  mem_image [MEM_BYTES];
  logic [31:0] pc_image;
  logic        stopped_image;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];
  int      fail_count = 0;
  // Items left in the current calm stretch (no idling) of the feeder; the sink keeps its own.
  int      feed_calm = 0;

  // Builds an instruction record; the optional part is the hand-written result.
  function automatic instr_t instr(input logic [3:0] opc, input logic [7:0] a, b, c,
                                   input bit typed = 1'b0, input status_t st = ST_RUN,
                                   input logic [31:0] pc = '0, input logic wr = 1'b0,
                                   input logic [31:0] val = '0);
    instr_t s;
    s.opc = opc;
    s.a = a;
    s.b = b;
    s.c = c;
    s.typed = typed;
    s.res.st = st;
    s.res.pc = pc;
    s.res.wr = wr;
    s.res.val = val;
    return s;
  endfunction

  // Number of idle cycles before the next item on one side. Now and then a calm
  // stretch of back-to-back items starts, so that the full rate is also seen.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left == 0 && $urandom_range(0, 7) == 0)
      calm_left = $urandom_range(10, 40);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // Executes one instruction on the shadow state and returns its result.
  function automatic result_t execute_instr(input logic [3:0] opc, input logic [7:0] a, b, c);
    result_t     r;
    logic        use_a;
    logic        use_b;
    logic        use_c;
    logic [31:0] addr;
    logic [31:0] val;
    r.st = ST_RUN;
    r.pc = pc_image;
    r.wr = 1'b0;
    r.val = '0;
    use_a = 1'b0;
    use_b = 1'b0;
    use_c = 1'b0;
    addr = '0;
    val = '0;
    // A stopped machine ignores everything and keeps reporting halted.
    if (stopped_image) begin
      r.st = ST_HALT;
      return r;
    end
    case (opc) inside
      OP_LOAD, OP_STORE, OP_MOVE: begin
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_PUTI, OP_ITE: use_a = 1'b1;
      OP_ADD, OP_SUB, OP_GT, OP_GE, OP_EQ: begin
        use_a = 1'b1;
        use_b = 1'b1;
        use_c = 1'b1;
      end
      default: ;
    endcase
    // A bad register index drops the instruction without touching anything.
    if ((use_a && a >= NUM_REGS) || (use_b && b >= NUM_REGS) || (use_c && c >= NUM_REGS)) begin
      r.st = ST_REGFAULT;
      return r;
    end
    // An address past the end of memory stops the machine where it stands.
    if (opc == OP_LOAD || opc == OP_STORE) begin
      addr = (opc == OP_LOAD) ? reg_image[b] : reg_image[a];
      if (addr >= MEM_BYTES) begin
        stopped_image = 1'b1;
        r.st = ST_MEMFAULT;
        return r;
      end
    end
    r.pc = pc_image + 32'd1;
    r.wr = 1'b1;
    case (opc)
      OP_HALT: begin
        stopped_image = 1'b1;
        r.st = ST_HALT;
        r.pc = pc_image;
        r.wr = 1'b0;
      end
      OP_LOAD: begin
        val = {24'd0, mem_image[addr]};
        reg_image[a] = val;
      end
      OP_STORE: begin
        val = {24'd0, reg_image[b][7:0]};
        mem_image[addr] = val[7:0];
      end
      OP_MOVE: begin
        val = reg_image[b];
        reg_image[a] = val;
      end
      OP_PUTI: begin
        val = {24'd0, b};
        reg_image[a] = val;
      end
      OP_ADD: begin
        val = reg_image[b] + reg_image[c];
        reg_image[a] = val;
      end
      OP_SUB: begin
        val = reg_image[b] - reg_image[c];
        reg_image[a] = val;
      end
      OP_GT: begin
        val = {31'd0, reg_image[b] > reg_image[c]};
        reg_image[a] = val;
      end
      OP_GE: begin
        val = {31'd0, reg_image[b] >= reg_image[c]};
        reg_image[a] = val;
      end
      OP_EQ: begin
        val = {31'd0, reg_image[b] == reg_image[c]};
        reg_image[a] = val;
      end
      OP_ITE: begin
        r.pc = (reg_image[a] != 32'd0) ? {24'd0, b} : {24'd0, c};
        r.wr = 1'b0;
      end
      OP_JUMP: begin
        r.pc = {24'd0, a};
        r.wr = 1'b0;
      end
      default: r.wr = 1'b0;
    endcase
    if (r.wr)
      r.val = val;
    pc_image = r.pc;
    return r;
  endfunction

  // Draws a mostly well-formed instruction. Loads and stores only use address
  // registers that hold an in-range address, so the machine keeps running; a
  // small share of the items carries a bad register index or a spare opcode.
  function automatic void random_instr(output logic [3:0] o, output logic [7:0] a, b, c);
    int pick;
    int ok_regs [$];
    pick = $urandom_range(0, 99);
    a = 8'($urandom_range(0, NUM_REGS - 1));
    b = 8'($urandom_range(0, NUM_REGS - 1));
    c = 8'($urandom_range(0, NUM_REGS - 1));
    if (pick < 3) begin
      o = 4'($urandom_range(OP_ADD, OP_EQ));
      c = 8'($urandom_range(NUM_REGS, 255));
    end else if (pick < 6) begin
      o = 4'($urandom_range(OP_LOAD, OP_EQ));
      b = 8'($urandom_range(NUM_REGS, 255));
    end else if (pick < 9) begin
      o = 4'($urandom_range(OP_LOAD, OP_ITE));
      a = 8'($urandom_range(NUM_REGS, 255));
    end else if (pick < 13) begin
      o = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
    end else if (pick < 18) begin
      o = OP_JUMP;
      a = 8'($urandom_range(0, 255));
    end else if (pick < 27) begin
      o = OP_ITE;
      b = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
    end else if (pick < 39) begin
      o = OP_PUTI;
      b = 8'($urandom_range(0, 255));
    end else if (pick < 63) begin
      for (int i = 0; i < NUM_REGS; i++)
        if (reg_image[i] < MEM_BYTES)
          ok_regs.push_back(i);
      if (ok_regs.size() == 0) begin
        o = OP_PUTI;
        b = 8'($urandom_range(0, 255));
      end else if (pick < 51) begin
        o = OP_LOAD;
        b = 8'(ok_regs[$urandom_range(0, ok_regs.size() - 1)]);
      end else begin
        o = OP_STORE;
        a = 8'(ok_regs[$urandom_range(0, ok_regs.size() - 1)]);
      end
    end else begin
      o = ($urandom_range(0, 5) == 0) ? OP_MOVE : 4'($urandom_range(OP_ADD, OP_EQ));
    end
  endfunction

  // Presents one instruction after a random gap and holds it until it is taken.
  // The valid line is only lowered when a gap follows, so it never gets two
  // assignments in one time step. The expectation is queued at acceptance.
  task automatic send_instr(input instr_t s);
    int      gap;
    result_t predicted;
    gap = draw_wait(feed_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= s.opc;
    operand_a <= s.a;
    operand_b <= s.b;
    operand_c <= s.c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = execute_instr(s.opc, s.a, s.b, s.c);
    pending_results.push_back(s.typed ? s.res : predicted);
  endtask

  // Result sink: stalls at random, then takes each result item and compares it
  // field by field with the oldest expectation.
  initial begin : result_sink
    result_t want;
    int      stall;
    int      sink_calm;
    sink_calm = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d next_pc %h write %0b value %h",
                 $time, status, next_pc, write_valid, write_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d, got %0d", $time, want.st, status);
          fail_count++;
        end
        if (next_pc !== want.pc) begin
          $display("%0t: next_pc expected %h, got %h", $time, want.pc, next_pc);
          fail_count++;
        end
        if (write_valid !== want.wr) begin
          $display("%0t: write_valid expected %0b, got %0b", $time, want.wr, write_valid);
          fail_count++;
        end
        if (write_value !== want.val) begin
          $display("%0t: write_value expected %h, got %h", $time, want.val, write_value);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    instr_t     plan [$];
    logic [3:0] o;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;

    // The shadow state starts where the block starts after reset.
    foreach (reg_image[i]) reg_image[i] = '0;
    foreach (mem_image[i]) mem_image[i] = '0;
    pc_image = '0;
    stopped_image = 1'b0;

    // Directed table. The first rows read directly off the reset state and the
    // register fault rule, so their results are written out here: a fault leaves
    // the program counter where it was.
    plan.push_back(instr(OP_PUTI, 7, 255, 0, 1'b1, ST_RUN, 32'd1, 1'b1, 32'd255));
    plan.push_back(instr(OP_EQ, 1, 0, 0, 1'b1, ST_RUN, 32'd2, 1'b1, 32'd1));
    plan.push_back(instr(OP_LOAD, 2, 0, 0, 1'b1, ST_RUN, 32'd3, 1'b1, 32'd0));
    plan.push_back(instr(OP_PUTI, 8, 0, 0, 1'b1, ST_REGFAULT, 32'd3));
    plan.push_back(instr(OP_ADD, 0, 255, 0, 1'b1, ST_REGFAULT, 32'd3));
    plan.push_back(instr(OP_SUB, 0, 0, 200, 1'b1, ST_REGFAULT, 32'd3));
    plan.push_back(instr(OP_ITE, 9, 1, 2, 1'b1, ST_REGFAULT, 32'd3));
    // Build the last memory address, 8191, in r1 by doubling and adding, then
    // store to it and read it back through the same register.
    plan.push_back(instr(OP_PUTI, 1, 255, 0));
    repeat (5) plan.push_back(instr(OP_ADD, 1, 1, 1));
    plan.push_back(instr(OP_PUTI, 2, 31, 0));
    plan.push_back(instr(OP_ADD, 1, 1, 2));
    plan.push_back(instr(OP_STORE, 1, 7, 0));
    plan.push_back(instr(OP_LOAD, 3, 1, 0));
    // Subtraction below zero wraps; the compares then see a huge unsigned value.
    plan.push_back(instr(OP_SUB, 4, 0, 7));
    plan.push_back(instr(OP_GT, 5, 4, 7));
    plan.push_back(instr(OP_GE, 6, 7, 7));
    plan.push_back(instr(OP_MOVE, 6, 4, 0));
    plan.push_back(instr(OP_SPARE_FIRST + 4'd1, 255, 255, 255));
    // Branch both ways, to the lowest and highest targets.
    plan.push_back(instr(OP_ITE, 1, 255, 0));
    plan.push_back(instr(OP_ITE, 0, 7, 200));
    plan.push_back(instr(OP_JUMP, 255, 0, 0));
    plan.push_back(instr(OP_JUMP, 0, 0, 0));
    plan.push_back(instr(OP_SPARE_LAST, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The block clears its memory first; the first send simply waits on in_ready.
    foreach (plan[i]) send_instr(plan[i]);

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      // Once in the run, hold off until every result has come back.
      if (n == DRAIN_POINT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      random_instr(o, a, b, c);
      send_instr(instr(o, a, b, c));
    end

    // Stopping is permanent, so it comes last: either a halt, or a load or a
    // store through an address register that holds all ones.
    case ($urandom_range(0, 2))
      0: send_instr(instr(OP_HALT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255))));
      1: begin
        send_instr(instr(OP_PUTI, 5, 1, 0));
        send_instr(instr(OP_PUTI, 6, 0, 0));
        send_instr(instr(OP_SUB, 5, 6, 5));
        send_instr(instr(OP_LOAD, 0, 5, 0));
      end
      default: begin
        send_instr(instr(OP_PUTI, 5, 1, 0));
        send_instr(instr(OP_PUTI, 6, 0, 0));
        send_instr(instr(OP_SUB, 5, 6, 5));
        send_instr(instr(OP_STORE, 5, 0, 0));
      end
    endcase

    // Anything at all after the stop must report halted and change nothing.
    for (int n = 0; n < STOPPED_COUNT; n++)
      send_instr(instr(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Give a stray extra result the chance to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("byte_vm_instruction_execute_top_test: clean");
    else
      $display("byte_vm_instruction_execute_top_test: errors");
    $finish;
  end

  // Watchdog: the slowest correct run, memory sweep included, takes well under
  // half a millisecond.
  initial begin : watchdog
    #5ms;
    $display("byte_vm_instruction_execute_top_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
